>>> sv/ioe_pkg.sv
// Shared types, operation codes and constants for the IR operation execute unit.
package ioe_pkg;

    localparam int VALUE_SLOTS_DEF   = 256;
    localparam int CONTEXT_WORDS_DEF = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [63:0] MASK32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] MASK16 = 64'h0000_0000_0000_FFFF;

    typedef enum logic [4:0] {
        CMD_BEGIN    = 5'd0,
        CMD_TARGET   = 5'd1,
        CMD_END      = 5'd2,
        CMD_CONDJUMP = 5'd3,
        CMD_CONST    = 5'd4,
        CMD_LDCTX    = 5'd5,
        CMD_STCTX    = 5'd6,
        CMD_ADD      = 5'd7,
        CMD_SUB      = 5'd8,
        CMD_OR       = 5'd9,
        CMD_XOR      = 5'd10,
        CMD_SHL      = 5'd11,
        CMD_SHR      = 5'd12,
        CMD_AND      = 5'd13,
        CMD_ANDN     = 5'd14,
        CMD_BEXT     = 5'd15,
        CMD_SELEQ    = 5'd16,
        CMD_SELNE    = 5'd17,
        CMD_TRUNC32  = 5'd18,
        CMD_TRUNC16  = 5'd19
    } cmd_t;

    typedef enum logic [3:0] {
        K_BEGIN,
        K_NOP,
        K_END,
        K_JUMP,
        K_CONST,
        K_LDCTX,
        K_STCTX,
        K_ALU,
        K_BAD
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  cmd;
        logic [7:0]  dest_slot;
        logic [7:0]  src_a;
        logic [7:0]  src_b;
        logic [7:0]  src_c;
        logic [7:0]  src_d;
        logic [63:0] constant_value;
        logic [31:0] rip_increment;
        logic [7:0]  jump_target;
        logic [4:0]  context_index;
    } op_t;

    typedef struct packed {
        logic [63:0] result_value;
        logic        branch_taken;
        logic [7:0]  branch_dest;
        logic        block_done;
        logic [63:0] program_counter;
        logic        bad_op;
    } res_t;

endpackage

>>> sv/ioe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ioe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/ioe_fifo.sv
// Small register FIFO used for the decode queue and the result queue.
module ioe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> sv/ioe_front.sv
// Front end: accepts operations, classifies them and queues them for execution.
module ioe_front
    import ioe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  cmd,
    input  logic [7:0]  dest_slot,
    input  logic [7:0]  src_a,
    input  logic [7:0]  src_b,
    input  logic [7:0]  src_c,
    input  logic [7:0]  src_d,
    input  logic [63:0] constant_value,
    input  logic [31:0] rip_increment,
    input  logic [7:0]  jump_target,
    input  logic [4:0]  context_index,
    output logic        head_valid,
    output op_t         head,
    input  logic        head_pop
);

    op_t   op;
    kind_t kind;
    logic  q_empty;

    always_comb
    begin
        unique case (cmd)
            CMD_BEGIN:    kind = K_BEGIN;
            CMD_TARGET:   kind = K_NOP;
            CMD_END:      kind = K_END;
            CMD_CONDJUMP: kind = K_JUMP;
            CMD_CONST:    kind = K_CONST;
            CMD_LDCTX:    kind = K_LDCTX;
            CMD_STCTX:    kind = K_STCTX;
            CMD_ADD, CMD_SUB, CMD_OR, CMD_XOR, CMD_SHL, CMD_SHR, CMD_AND,
            CMD_ANDN, CMD_BEXT, CMD_SELEQ, CMD_SELNE, CMD_TRUNC32,
            CMD_TRUNC16:  kind = K_ALU;
            default:      kind = K_BAD;
        endcase
    end

    always_comb
    begin
        op.kind           = kind;
        op.cmd            = cmd;
        op.dest_slot      = dest_slot;
        op.src_a          = src_a;
        op.src_b          = src_b;
        op.src_c          = src_c;
        op.src_d          = src_d;
        op.constant_value = constant_value;
        op.rip_increment  = rip_increment;
        op.jump_target    = jump_target;
        op.context_index  = context_index;
    end

    ioe_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (op),
        .full  (full),
        .pop   (head_pop),
        .dout  (head),
        .empty (q_empty)
    );

    assign head_valid = !q_empty;

endmodule

>>> sv/ioe_back.sv
// Back end: slot and context reads, forwarding, execution and state update.
module ioe_back
    import ioe_pkg::*;
#(
    parameter int VALUE_SLOTS   = VALUE_SLOTS_DEF,
    parameter int CONTEXT_WORDS = CONTEXT_WORDS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic head_valid,
    input  op_t  head,
    output logic head_pop,
    output logic out_push,
    output res_t out_data,
    input  logic out_full
);

    localparam int SW = $clog2(VALUE_SLOTS);
    localparam int CW = (CONTEXT_WORDS > 1) ? $clog2(CONTEXT_WORDS) : 1;

    typedef logic [SW-1:0] stab_t [256];
    typedef logic [CW-1:0] ctab_t [32];

    function automatic stab_t slot_tab();
        stab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = SW'(i % VALUE_SLOTS);
        end
        return t;
    endfunction

    function automatic ctab_t ctx_tab();
        ctab_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = CW'(i % CONTEXT_WORDS);
        end
        return t;
    endfunction

    localparam stab_t SLOT_TAB = slot_tab();
    localparam ctab_t CTX_TAB  = ctx_tab();

    // issue side
    logic          issue;
    logic [SW-1:0] ia, ib, ic, id;

    // execute stage
    logic          x_v_reg, x_v_next;
    op_t           x_op_reg;
    logic [SW-1:0] x_ia_reg, x_ib_reg, x_ic_reg, x_id_reg, x_dst_reg;
    logic [CW-1:0] x_ctx_reg;
    logic          x_fire;

    logic [63:0]   qa, qb, qc, qd, qctx;

    // last slot write and last context write, for read-during-write forwarding
    logic          lw_v_reg, lw_v_next;
    logic [SW-1:0] lw_idx_reg;
    logic [63:0]   lw_data_reg;
    logic          lc_v_reg, lc_v_next;
    logic [CW-1:0] lc_idx_reg;
    logic [63:0]   lc_data_reg;

    logic [VALUE_SLOTS-1:0]   valid_reg, valid_next;
    logic [CONTEXT_WORDS-1:0] cvalid_reg, cvalid_next;
    logic [63:0]              pc_reg, pc_next;

    logic [63:0] a, b, c, d, ctxv, res, shr_ab;
    logic        writes, is_begin, is_st, is_end, taken;

    assign ia = SLOT_TAB[head.src_a];
    assign ib = SLOT_TAB[head.src_b];
    assign ic = SLOT_TAB[head.src_c];
    assign id = SLOT_TAB[head.src_d];

    assign x_fire   = x_v_reg && !out_full;
    assign issue    = head_valid && (!x_v_reg || x_fire);
    assign head_pop = issue;
    assign out_push = x_fire;

    assign is_begin = (x_op_reg.kind == K_BEGIN);
    assign is_st    = (x_op_reg.kind == K_STCTX);
    assign is_end   = (x_op_reg.kind == K_END);
    assign writes   = (x_op_reg.kind == K_CONST) || (x_op_reg.kind == K_LDCTX) ||
                      (x_op_reg.kind == K_ALU);

    ioe_ram #(.WIDTH(64), .DEPTH(VALUE_SLOTS)) u_slots_a (
        .clk(clk), .we(x_fire && writes), .waddr(x_dst_reg), .wdata(res),
        .re(issue), .raddr(ia), .rdata(qa)
    );
    ioe_ram #(.WIDTH(64), .DEPTH(VALUE_SLOTS)) u_slots_b (
        .clk(clk), .we(x_fire && writes), .waddr(x_dst_reg), .wdata(res),
        .re(issue), .raddr(ib), .rdata(qb)
    );
    ioe_ram #(.WIDTH(64), .DEPTH(VALUE_SLOTS)) u_slots_c (
        .clk(clk), .we(x_fire && writes), .waddr(x_dst_reg), .wdata(res),
        .re(issue), .raddr(ic), .rdata(qc)
    );
    ioe_ram #(.WIDTH(64), .DEPTH(VALUE_SLOTS)) u_slots_d (
        .clk(clk), .we(x_fire && writes), .waddr(x_dst_reg), .wdata(res),
        .re(issue), .raddr(id), .rdata(qd)
    );
    ioe_ram #(.WIDTH(64), .DEPTH(CONTEXT_WORDS)) u_ctx (
        .clk(clk), .we(x_fire && is_st), .waddr(x_ctx_reg), .wdata(a),
        .re(issue), .raddr(CTX_TAB[head.context_index]), .rdata(qctx)
    );

    function automatic logic [63:0] slot_val(
        input logic [SW-1:0]          idx,
        input logic [63:0]            q,
        input logic                   lwv,
        input logic [SW-1:0]          lwi,
        input logic [63:0]            lwd,
        input logic [VALUE_SLOTS-1:0] vld
    );
        logic [63:0] v;
        if (lwv && (lwi == idx))
        begin
            v = lwd;
        end
        else
        begin
            v = vld[idx] ? q : 64'd0;
        end
        return v;
    endfunction

    always_comb
    begin
        a = slot_val(x_ia_reg, qa, lw_v_reg, lw_idx_reg, lw_data_reg, valid_reg);
        b = slot_val(x_ib_reg, qb, lw_v_reg, lw_idx_reg, lw_data_reg, valid_reg);
        c = slot_val(x_ic_reg, qc, lw_v_reg, lw_idx_reg, lw_data_reg, valid_reg);
        d = slot_val(x_id_reg, qd, lw_v_reg, lw_idx_reg, lw_data_reg, valid_reg);
        if (lc_v_reg && (lc_idx_reg == x_ctx_reg))
        begin
            ctxv = lc_data_reg;
        end
        else
        begin
            ctxv = cvalid_reg[x_ctx_reg] ? qctx : 64'd0;
        end
    end

    assign shr_ab = (|b[63:6]) ? 64'd0 : (a >> b[5:0]);

    always_comb
    begin
        if (x_op_reg.kind == K_CONST)
        begin
            res = x_op_reg.constant_value;
        end
        else if (x_op_reg.kind == K_LDCTX)
        begin
            res = ctxv;
        end
        else
        begin
            unique case (x_op_reg.cmd)
                CMD_ADD:     res = a + b;
                CMD_SUB:     res = a - b;
                CMD_OR:      res = a | b;
                CMD_XOR:     res = a ^ b;
                CMD_SHL:     res = (|b[63:6]) ? 64'd0 : (a << b[5:0]);
                CMD_SHR:     res = shr_ab;
                CMD_AND:     res = a & b;
                CMD_ANDN:    res = a & ~b;
                CMD_BEXT:    res = {63'd0, shr_ab[0]};
                CMD_SELEQ:   res = (a == b) ? c : d;
                CMD_SELNE:   res = (a != b) ? c : d;
                CMD_TRUNC32: res = a & MASK32;
                CMD_TRUNC16: res = a & MASK16;
                default:     res = 64'd0;
            endcase
        end
    end

    assign taken   = (x_op_reg.kind == K_JUMP) && (a != 64'd0);
    assign pc_next = is_end ? pc_reg + {32'd0, x_op_reg.rip_increment} : pc_reg;

    always_comb
    begin
        out_data.result_value    = writes ? res : 64'd0;
        out_data.branch_taken    = taken;
        out_data.branch_dest     = taken ? x_op_reg.jump_target : 8'd0;
        out_data.block_done      = is_end;
        out_data.program_counter = pc_next;
        out_data.bad_op          = (x_op_reg.kind == K_BAD);
    end

    always_comb
    begin
        x_v_next    = issue ? 1'b1 : (x_fire ? 1'b0 : x_v_reg);
        valid_next  = valid_reg;
        cvalid_next = cvalid_reg;
        lw_v_next   = lw_v_reg;
        lc_v_next   = lc_v_reg;
        if (x_fire)
        begin
            if (is_begin)
            begin
                valid_next = '0;
                lw_v_next  = 1'b0;
            end
            else if (writes)
            begin
                valid_next[x_dst_reg] = 1'b1;
                lw_v_next             = 1'b1;
            end
            if (is_st)
            begin
                cvalid_next[x_ctx_reg] = 1'b1;
                lc_v_next              = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_v_reg    <= 1'b0;
            valid_reg  <= '0;
            cvalid_reg <= '0;
            lw_v_reg   <= 1'b0;
            lc_v_reg   <= 1'b0;
            pc_reg     <= 64'd0;
        end
        else
        begin
            x_v_reg    <= x_v_next;
            valid_reg  <= valid_next;
            cvalid_reg <= cvalid_next;
            lw_v_reg   <= lw_v_next;
            lc_v_reg   <= lc_v_next;
            if (x_fire)
            begin
                pc_reg <= pc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            x_op_reg  <= head;
            x_ia_reg  <= ia;
            x_ib_reg  <= ib;
            x_ic_reg  <= ic;
            x_id_reg  <= id;
            x_dst_reg <= SLOT_TAB[head.dest_slot];
            x_ctx_reg <= CTX_TAB[head.context_index];
        end
        if (x_fire && writes)
        begin
            lw_idx_reg  <= x_dst_reg;
            lw_data_reg <= res;
        end
        if (x_fire && is_st)
        begin
            lc_idx_reg  <= x_ctx_reg;
            lc_data_reg <= a;
        end
    end

endmodule

>>> sv/ir_op_execute_unit.sv
// IR operation execute unit: one operation in, one result out, queue-style on both sides.
//
// Input channel: drive the operation fields and raise push; the operation is
// transferred at a clock edge with push high and full low.
// Result channel: while empty is low the oldest result sits on the result
// ports; it is transferred at a clock edge with pop high and empty low.
// Path: an operation's slots are read as it leaves the decode queue into the
// execute register, then it executes into the result queue, whose oldest
// entry drives the result ports.
// Throughput: one operation per cycle unless the result queue is full; dependent
// operations back to back get the last slot and context writes forwarded around the RAMs.
// Slot storage is four RAM copies, one per operand read port.
// Reset clears the program counter, all slot written marks and context marks,
// and empties both queues; no clearing pass is needed.
// If pop stays low the result queue fills, the execute stage holds, and full
// rises once the decode queue is also full.
module ir_op_execute_unit
    import ioe_pkg::*;
#(
    parameter int VALUE_SLOTS   = VALUE_SLOTS_DEF,
    parameter int CONTEXT_WORDS = CONTEXT_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  cmd,
    input  logic [7:0]  dest_slot,
    input  logic [7:0]  src_a,
    input  logic [7:0]  src_b,
    input  logic [7:0]  src_c,
    input  logic [7:0]  src_d,
    input  logic [63:0] constant_value,
    input  logic [31:0] rip_increment,
    input  logic [7:0]  jump_target,
    input  logic [4:0]  context_index,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] result_value,
    output logic        branch_taken,
    output logic [7:0]  branch_dest,
    output logic        block_done,
    output logic [63:0] program_counter,
    output logic        bad_op
);

    logic head_valid, head_pop, out_push, out_full;
    op_t  head;
    res_t out_data, res_head;

    ioe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .cmd            (cmd),
        .dest_slot      (dest_slot),
        .src_a          (src_a),
        .src_b          (src_b),
        .src_c          (src_c),
        .src_d          (src_d),
        .constant_value (constant_value),
        .rip_increment  (rip_increment),
        .jump_target    (jump_target),
        .context_index  (context_index),
        .head_valid     (head_valid),
        .head           (head),
        .head_pop       (head_pop)
    );

    ioe_back #(
        .VALUE_SLOTS   (VALUE_SLOTS),
        .CONTEXT_WORDS (CONTEXT_WORDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .out_push   (out_push),
        .out_data   (out_data),
        .out_full   (out_full)
    );

    ioe_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_results (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_data),
        .full  (out_full),
        .pop   (pop),
        .dout  (res_head),
        .empty (empty)
    );

    assign result_value    = res_head.result_value;
    assign branch_taken    = res_head.branch_taken;
    assign branch_dest     = res_head.branch_dest;
    assign block_done      = res_head.block_done;
    assign program_counter = res_head.program_counter;
    assign bad_op          = res_head.bad_op;

endmodule
